// ----- rtl/trim_pkg.sv -----
// ----------------------------------------------------------------------------
// trim_pkg
// Shared types and constants of the tensor reverse index map unit.
// ----------------------------------------------------------------------------
package trim_pkg;

  localparam int MAX_DIMS    = 8;
  localparam int INDEX_BITS  = 24;
  localparam int OFS_BITS    = INDEX_BITS + 3;
  localparam int SIZE_BITS   = 16;
  // strides are held saturated at 2^INDEX_BITS, one bit above the index range
  localparam int STRIDE_BITS = INDEX_BITS + 1;
  localparam int DIM_BITS    = $clog2(MAX_DIMS);
  // quotient bits resolved per divide stage
  localparam int DIV_STEP    = 4;
  localparam int DIV_STAGES  = SIZE_BITS / DIV_STEP;

  localparam logic [STRIDE_BITS-1:0] STRIDE_CAP = STRIDE_BITS'(1) << INDEX_BITS;

  // register indexes
  localparam logic [2:0] REG_DIM_COUNT = 3'd0;
  localparam logic [2:0] REG_REV_MASK  = 3'd1;
  localparam logic [2:0] REG_SIZES_LO  = 3'd2;
  localparam logic [2:0] REG_SIZES_HI  = 3'd3;
  localparam logic [2:0] REG_ELEM_BYTES = 3'd4;

  // per-dimension settings derived from the registers
  // stride is saturated for the divide, mod_stride wraps at the index width
  typedef struct packed {
    logic [STRIDE_BITS-1:0] stride;
    logic [INDEX_BITS-1:0]  mod_stride;
    logic [SIZE_BITS-1:0]   size;
    logic                   mirror;
  } dim_cfg_t;

  // one index in flight
  typedef struct packed {
    logic                  valid;
    logic                  oor;
    logic [INDEX_BITS-1:0] idx;
    logic [INDEX_BITS-1:0] rem;
    logic [INDEX_BITS-1:0] acc;
  } item_t;

endpackage

// ----- rtl/trim_cfg.sv -----
// ----------------------------------------------------------------------------
// trim_cfg
// Register file and stride sequencer: after a write, walks the dimensions
// from innermost to outermost, one saturating multiply per cycle.
// ----------------------------------------------------------------------------
module trim_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [5:0]                            paddr,
  input  logic [63:0]                           pwdata,
  output logic [63:0]                           prdata,
  output logic                                  pready,
  output trim_pkg::dim_cfg_t [trim_pkg::MAX_DIMS-1:0] dims,
  output logic [trim_pkg::STRIDE_BITS-1:0]      total,
  output logic [3:0]                            elem_bytes,
  output logic                                  busy
);

  localparam int PW = trim_pkg::STRIDE_BITS + trim_pkg::SIZE_BITS;

  logic [3:0]  dim_count;
  logic [7:0]  rev_mask;
  logic [63:0] sizes_lo;
  logic [63:0] sizes_hi;
  logic [2:0]  reg_idx;
  logic        wr;

  logic [3:0]                         cnt;
  logic [trim_pkg::DIM_BITS-1:0]      d;
  logic [3:0]                         n;
  logic [trim_pkg::STRIDE_BITS-1:0]   run;
  logic [trim_pkg::STRIDE_BITS-1:0]   run_next;
  logic [trim_pkg::INDEX_BITS-1:0]    run_mod;
  logic [trim_pkg::INDEX_BITS-1:0]    run_mod_next;
  logic [PW-1:0]                      prod;
  logic [trim_pkg::SIZE_BITS-1:0]     size_d;
  logic [trim_pkg::STRIDE_BITS-1:0]   stride [trim_pkg::MAX_DIMS];
  logic [trim_pkg::INDEX_BITS-1:0]    mod_stride [trim_pkg::MAX_DIMS];
  logic [trim_pkg::MAX_DIMS-1:0]      mirror;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr      = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count  <= '0;
      rev_mask   <= '0;
      sizes_lo   <= 64'h0001_0001_0001_0001;
      sizes_hi   <= 64'h0001_0001_0001_0001;
      elem_bytes <= 4'd1;
    end else if (wr) begin
      unique case (reg_idx)
        trim_pkg::REG_DIM_COUNT:  dim_count  <= pwdata[3:0];
        trim_pkg::REG_REV_MASK:   rev_mask   <= pwdata[7:0];
        trim_pkg::REG_SIZES_LO:   sizes_lo   <= pwdata;
        trim_pkg::REG_SIZES_HI:   sizes_hi   <= pwdata;
        trim_pkg::REG_ELEM_BYTES: elem_bytes <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      trim_pkg::REG_DIM_COUNT:  prdata = {60'd0, dim_count};
      trim_pkg::REG_REV_MASK:   prdata = {56'd0, rev_mask};
      trim_pkg::REG_SIZES_LO:   prdata = sizes_lo;
      trim_pkg::REG_SIZES_HI:   prdata = sizes_hi;
      trim_pkg::REG_ELEM_BYTES: prdata = {60'd0, elem_bytes};
      default:                  prdata = '0;
    endcase
  end

  // sequencer step: dimension under work and its saturated product
  assign n    = (dim_count > 4'(trim_pkg::MAX_DIMS)) ? 4'(trim_pkg::MAX_DIMS) : dim_count;
  assign d    = trim_pkg::DIM_BITS'(cnt - 4'd1);
  assign busy = (cnt != 4'd0);

  always_comb begin
    if (d[2]) size_d = sizes_hi[16*d[1:0] +: 16];
    else      size_d = sizes_lo[16*d[1:0] +: 16];
  end

  assign prod     = PW'(run) * PW'(size_d);
  assign run_next = (prod > PW'(trim_pkg::STRIDE_CAP))
                    ? trim_pkg::STRIDE_CAP : prod[trim_pkg::STRIDE_BITS-1:0];
  // wrapped stride product for the source index sum
  assign run_mod_next = run_mod * trim_pkg::INDEX_BITS'(size_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      run     <= trim_pkg::STRIDE_BITS'(1);
      run_mod <= trim_pkg::INDEX_BITS'(1);
      mirror  <= '0;
      for (int i = 0; i < trim_pkg::MAX_DIMS; i++) begin
        stride[i]     <= trim_pkg::STRIDE_CAP;
        mod_stride[i] <= '0;
      end
    end else if (wr) begin
      cnt     <= 4'(trim_pkg::MAX_DIMS);
      run     <= trim_pkg::STRIDE_BITS'(1);
      run_mod <= trim_pkg::INDEX_BITS'(1);
    end else if (busy) begin
      cnt <= cnt - 4'd1;
      if (4'(d) < n) begin
        stride[d]     <= run;
        mod_stride[d] <= run_mod;
        mirror[d]     <= rev_mask[d];
        run           <= run_next;
        run_mod       <= run_mod_next;
      end else begin
        stride[d]     <= trim_pkg::STRIDE_CAP;
        mod_stride[d] <= '0;
        mirror[d]     <= 1'b0;
      end
    end
  end

  assign total = run;

  // per-dimension settings out
  always_comb begin
    for (int i = 0; i < trim_pkg::MAX_DIMS; i++) begin
      dims[i].stride     = stride[i];
      dims[i].mod_stride = mod_stride[i];
      dims[i].mirror     = mirror[i];
      dims[i].size       = (i < 4) ? sizes_lo[16*(i%4) +: 16] : sizes_hi[16*(i%4) +: 16];
    end
  end

endmodule

// ----- rtl/trim_dim.sv -----
// ----------------------------------------------------------------------------
// trim_dim
// One dimension: pipelined restoring divide of the remainder by the stride,
// optional mirror of the coordinate, then stride product and accumulate.
// ----------------------------------------------------------------------------
module trim_dim (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  trim_pkg::dim_cfg_t cfg,
  input  trim_pkg::item_t    in_item,
  output trim_pkg::item_t    out_item
);

  localparam int NS = trim_pkg::DIV_STAGES;
  localparam int WW = trim_pkg::STRIDE_BITS + trim_pkg::SIZE_BITS;
  localparam int PW = trim_pkg::INDEX_BITS + trim_pkg::SIZE_BITS;

  trim_pkg::item_t              pipe [NS+2];
  trim_pkg::item_t              div_in [NS];
  trim_pkg::item_t              div_out [NS];
  trim_pkg::item_t              acc_item;
  logic [trim_pkg::SIZE_BITS-1:0] quo [NS];
  logic [trim_pkg::SIZE_BITS-1:0] q_in [NS];
  logic [trim_pkg::SIZE_BITS-1:0] q_out [NS];
  logic [trim_pkg::SIZE_BITS-1:0] coord;
  logic [trim_pkg::INDEX_BITS-1:0] prod;
  logic [PW-1:0] prod_full;

  // divide stages, DIV_STEP quotient bits each
  for (genvar s = 0; s < NS; s++) begin : g_div
    if (s == 0) begin : g_first
      assign div_in[s] = in_item;
      assign q_in[s]   = '0;
    end else begin : g_rest
      assign div_in[s] = pipe[s-1];
      assign q_in[s]   = quo[s-1];
    end

    always_comb begin
      logic [WW-1:0] sh;
      int            j;
      div_out[s] = div_in[s];
      q_out[s]   = q_in[s];
      for (int k = 0; k < trim_pkg::DIV_STEP; k++) begin
        j  = trim_pkg::SIZE_BITS - 1 - trim_pkg::DIV_STEP * s - k;
        sh = WW'(cfg.stride) << j;
        if (WW'(div_out[s].rem) >= sh) begin
          div_out[s].rem = div_out[s].rem - sh[trim_pkg::INDEX_BITS-1:0];
          q_out[s][j]    = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[s] <= '0;
      end else if (adv) begin
        pipe[s] <= div_out[s];
        quo[s]  <= q_out[s];
      end
    end
  end

  // mirror and scale by the wrapped row-major stride
  assign coord     = cfg.mirror ? (cfg.size - 16'd1 - quo[NS-1]) : quo[NS-1];
  assign prod_full = PW'(coord) * PW'(cfg.mod_stride);

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[NS] <= '0;
    end else if (adv) begin
      pipe[NS] <= pipe[NS-1];
      prod     <= prod_full[trim_pkg::INDEX_BITS-1:0];
    end
  end

  // accumulate source index
  always_comb begin
    acc_item     = pipe[NS];
    acc_item.acc = pipe[NS].acc + prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[NS+1] <= '0;
    end else if (adv) begin
      pipe[NS+1] <= acc_item;
    end
  end

  assign out_item = pipe[NS+1];

endmodule

// ----- rtl/tensor_reverse_index_map_unit.sv -----
// ----------------------------------------------------------------------------
// tensor_reverse_index_map_unit
// Input transfer to result transfer passes through fifty register stages:
// an entry stage, six per dimension (four divide stages, a product stage,
// an accumulate stage) and the output register.
// Throughput: one index per cycle; the pipeline stalls as a whole on m_tready.
// After a register write the stride sequencer is busy, and no input is taken until it is done.
// Reset: synchronous, clears valid bits and restores register reset values.
// ----------------------------------------------------------------------------
module tensor_reverse_index_map_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // flat_index[23:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata   // source_index[23:0], source_byte_offset[50:24],
                                // dest_byte_offset[77:51], index_out_of_range[78]
);

  trim_pkg::dim_cfg_t [trim_pkg::MAX_DIMS-1:0] dims;
  logic [trim_pkg::STRIDE_BITS-1:0] total;
  logic [3:0]                       elem_bytes;
  logic                             busy;
  logic                             adv;
  trim_pkg::item_t                  chain [trim_pkg::MAX_DIMS+1];
  trim_pkg::item_t                  last;
  logic [trim_pkg::INDEX_BITS+3:0]  src_ofs;
  logic [trim_pkg::INDEX_BITS+3:0]  dst_ofs;
  logic [trim_pkg::INDEX_BITS-1:0]  out_src;
  logic [trim_pkg::OFS_BITS-1:0]    out_src_ofs;
  logic [trim_pkg::OFS_BITS-1:0]    out_dst_ofs;
  logic                             out_oor;

  trim_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .dims(dims), .total(total), .elem_bytes(elem_bytes), .busy(busy)
  );

  // whole-pipeline advance
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !busy;

  // entry stage: range check against the element count
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0] <= '0;
    end else if (adv) begin
      chain[0].valid <= s_tvalid && s_tready;
      chain[0].oor   <= trim_pkg::STRIDE_BITS'(s_tdata) >= total;
      chain[0].idx   <= s_tdata;
      chain[0].rem   <= s_tdata;
      chain[0].acc   <= '0;
    end
  end

  for (genvar g = 0; g < trim_pkg::MAX_DIMS; g++) begin : g_dim
    trim_dim u_dim (
      .clk(clk), .rst(rst), .adv(adv), .cfg(dims[g]),
      .in_item(chain[g]), .out_item(chain[g+1])
    );
  end

  assign last    = chain[trim_pkg::MAX_DIMS];
  assign src_ofs = (trim_pkg::OFS_BITS+1)'(last.acc) * (trim_pkg::OFS_BITS+1)'(elem_bytes);
  assign dst_ofs = (trim_pkg::OFS_BITS+1)'(last.idx) * (trim_pkg::OFS_BITS+1)'(elem_bytes);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_oor     <= last.oor;
      out_src     <= last.oor ? '0 : last.acc;
      out_src_ofs <= last.oor ? '0 : src_ofs[trim_pkg::OFS_BITS-1:0];
      out_dst_ofs <= dst_ofs[trim_pkg::OFS_BITS-1:0];
    end
  end

  assign m_tdata = {1'b0, out_oor, out_dst_ofs, out_src_ofs, out_src};

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the tensor reverse index map unit against its own index predictor.
// A directed table covers the reset state, dimension and size extremes, mirroring,
// zero-sized and oversized tensors and odd element sizes. Random phases follow, all
// but the first randomly configured. Both stream sides idle and stall at random.
// Every result is compared field by field with the oldest pending expectation.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int INDEX_BITS = trim_pkg::INDEX_BITS;
  localparam int OFS_BITS   = trim_pkg::OFS_BITS;
  localparam int MAX_DIMS   = trim_pkg::MAX_DIMS;
  localparam longint unsigned IDX_MASK = (64'd1 << INDEX_BITS) - 1;
  localparam longint unsigned OFS_MASK = (64'd1 << OFS_BITS) - 1;
  localparam longint unsigned SAT_LIMIT = 64'd1 << 33;
  localparam int PIPE_DRAIN = 60;
  localparam int SEQ_SETTLE = 12;

  typedef struct {
    logic [INDEX_BITS-1:0] src;
    logic [OFS_BITS-1:0]   src_ofs;
    logic [OFS_BITS-1:0]   dst_ofs;
    logic                  oor;
  } map_result_t;

  typedef struct {
    logic [3:0]  dims;
    logic [7:0]  mirror_mask;
    logic [63:0] sizes_lo;
    logic [63:0] sizes_hi;
    logic [3:0]  elem_bytes;
  } tensor_cfg_t;

  typedef struct {
    int                    cfg_sel;
    logic [INDEX_BITS-1:0] idx;
    bit                    typed;
    map_result_t           res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;

  // shadow of the register file
  tensor_cfg_t shadow_cfg;
  map_result_t pending_maps[$];
  int          fail_count = 0;

  tensor_reverse_index_map_unit dut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned dim_size(int d);
    return (d < 4) ? longint'(shadow_cfg.sizes_lo[16*d +: 16])
                   : longint'(shadow_cfg.sizes_hi[16*(d-4) +: 16]);
  endfunction

  function automatic int dims_used();
    return (shadow_cfg.dims > MAX_DIMS) ? MAX_DIMS : int'(shadow_cfg.dims);
  endfunction

  function automatic longint unsigned sat_mul(longint unsigned a, longint unsigned b);
    longint unsigned p;
    p = a * b;
    return (p > SAT_LIMIT) ? SAT_LIMIT : p;
  endfunction

  function automatic longint unsigned element_count();
    longint unsigned total;
    total = 1;
    for (int d = 0; d < dims_used(); d++) total = sat_mul(total, dim_size(d));
    return total;
  endfunction

  // mirrored source address for one flat output index
  function automatic map_result_t reverse_map(logic [INDEX_BITS-1:0] idx);
    longint unsigned sat_st[MAX_DIMS];
    longint unsigned mod_st[MAX_DIMS];
    longint unsigned rem, coord, src, eb;
    int n;
    map_result_t r;
    n = dims_used();
    eb = shadow_cfg.elem_bytes;
    src = 0;
    rem = idx;
    if (n > 0) begin
      sat_st[n-1] = 1;
      mod_st[n-1] = 1;
      for (int d = n - 1; d > 0; d--) begin
        sat_st[d-1] = sat_mul(sat_st[d], dim_size(d));
        mod_st[d-1] = (mod_st[d] * dim_size(d)) & IDX_MASK;
      end
    end
    r.oor = (longint'(idx) >= element_count());
    if (!r.oor) begin
      for (int d = 0; d < n; d++) begin
        coord = 0;
        if (sat_st[d] != 0) begin
          coord = rem / sat_st[d];
          rem = rem % sat_st[d];
        end
        if (shadow_cfg.mirror_mask[d]) coord = dim_size(d) - 1 - coord;
        src = (src + coord * mod_st[d]) & IDX_MASK;
      end
    end
    r.src = r.oor ? '0 : src[INDEX_BITS-1:0];
    r.src_ofs = r.oor ? '0 : OFS_BITS'((src * eb) & OFS_MASK);
    r.dst_ofs = OFS_BITS'((longint'(idx) * eb) & OFS_MASK);
    return r;
  endfunction

  // register write with a setup phase and an access phase, select stays up for the next write
  task automatic reg_write(logic [2:0] sel, logic [63:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {sel, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  // drain the pipeline, then rewrite every register
  task automatic load_cfg(tensor_cfg_t c);
    wait (pending_maps.size() == 0);
    repeat (PIPE_DRAIN) @(posedge clk);
    reg_write(trim_pkg::REG_DIM_COUNT, 64'(c.dims));
    reg_write(trim_pkg::REG_REV_MASK, 64'(c.mirror_mask));
    reg_write(trim_pkg::REG_SIZES_LO, c.sizes_lo);
    reg_write(trim_pkg::REG_SIZES_HI, c.sizes_hi);
    reg_write(trim_pkg::REG_ELEM_BYTES, 64'(c.elem_bytes));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_cfg = c;
    repeat (SEQ_SETTLE) @(posedge clk);
  endtask

  // one input transfer; valid stays high across back-to-back items
  task automatic send_index(logic [INDEX_BITS-1:0] idx, bit typed, map_result_t res,
                            int max_gap);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= idx;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_maps.push_back(typed ? res : reverse_map(idx));
  endtask

  function automatic tensor_cfg_t random_cfg();
    tensor_cfg_t c;
    logic [15:0] sz[MAX_DIMS];
    int mode;
    mode = $urandom_range(0, 9);
    c.dims = (mode < 7) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
    for (int d = 0; d < MAX_DIMS; d++) begin
      case ($urandom_range(0, 19))
        0: sz[d] = 16'($urandom);
        1: sz[d] = 16'hffff;
        2: sz[d] = 16'h0000;
        default: sz[d] = 16'($urandom_range(1, 6));
      endcase
    end
    c.sizes_lo = {sz[3], sz[2], sz[1], sz[0]};
    c.sizes_hi = {sz[7], sz[6], sz[5], sz[4]};
    c.mirror_mask = 8'($urandom);
    c.elem_bytes = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
    return c;
  endfunction

  // result side: random stalls, compare with oldest expectation
  initial begin
    int gap;
    map_result_t want;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (pending_maps.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        fail_count++;
      end else begin
        want = pending_maps.pop_front();
        if (m_tdata[23:0] !== want.src || m_tdata[50:24] !== want.src_ofs ||
            m_tdata[77:51] !== want.dst_ofs || m_tdata[78] !== want.oor) begin
          $display("%0t: mismatch expected src=%h sofs=%h dofs=%h oor=%b",
                   $time, want.src, want.src_ofs, want.dst_ofs, want.oor);
          $display("%0t:          actual   src=%h sofs=%h dofs=%h oor=%b",
                   $time, m_tdata[23:0], m_tdata[50:24], m_tdata[77:51], m_tdata[78]);
          fail_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // stimulus
  initial begin
    tensor_cfg_t cfgs[6];
    stim_row_t rows[$];
    map_result_t none;
    tensor_cfg_t rc;
    longint unsigned total;
    logic [INDEX_BITS-1:0] idx;
    int cur_cfg;
    int max_gap;

    none = '{src: '0, src_ofs: '0, dst_ofs: '0, oor: 1'b0};
    shadow_cfg = '{dims: 4'd0, mirror_mask: 8'h00, sizes_lo: 64'h0001000100010001,
                   sizes_hi: 64'h0001000100010001, elem_bytes: 4'd1};
    cfgs[0] = shadow_cfg;
    // 2x3x4, outer and inner axes mirrored
    cfgs[1] = '{4'd3, 8'b0000_0101, 64'h0000_0004_0003_0002, 64'h0001000100010001, 4'd4};
    // dim count above the maximum, all axes mirrored
    cfgs[2] = '{4'd15, 8'hff, 64'h0002000200020002, 64'h0002000200020002, 4'd8};
    // zero-sized dimension
    cfgs[3] = '{4'd2, 8'h03, 64'h0000_0000_0000_0005, 64'h0, 4'd15};
    // oversized tensor, zero element size
    cfgs[4] = '{4'd8, 8'haa, 64'hffffffffffffffff, 64'hffffffffffffffff, 4'd0};
    // mask bits above the used dimensions
    cfgs[5] = '{4'd1, 8'hfe, 64'h0000_0000_0000_ffff, 64'h0, 4'd1};

    rows = '{
      '{0, 24'd0,       1, '{24'd0, 27'd0, 27'd0, 1'b0}},
      '{0, 24'd1,       1, '{24'd0, 27'd0, 27'd1, 1'b1}},
      '{0, 24'hffffff,  1, '{24'd0, 27'd0, 27'hffffff, 1'b1}},
      '{1, 24'd0,       0, none},
      '{1, 24'd7,       0, none},
      '{1, 24'd23,      0, none},
      '{1, 24'd24,      1, '{24'd0, 27'd0, 27'd96, 1'b1}},
      '{2, 24'd0,       1, '{24'd255, 27'd2040, 27'd0, 1'b0}},
      '{2, 24'd255,     1, '{24'd0, 27'd0, 27'd2040, 1'b0}},
      '{2, 24'd256,     1, '{24'd0, 27'd0, 27'd2048, 1'b1}},
      '{3, 24'd0,       1, '{24'd0, 27'd0, 27'd0, 1'b1}},
      '{3, 24'hffffff,  0, none},
      '{4, 24'd0,       0, none},
      '{4, 24'h123456,  0, none},
      '{4, 24'hffffff,  0, none},
      '{5, 24'd5,       1, '{24'd5, 27'd5, 27'd5, 1'b0}},
      '{5, 24'hfffe,    0, none},
      '{5, 24'hffff,    1, '{24'd0, 27'd0, 27'hffff, 1'b1}}
    };

    // reset
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    cur_cfg = 0;
    foreach (rows[i]) begin
      if (rows[i].cfg_sel != cur_cfg) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        load_cfg(cfgs[rows[i].cfg_sel]);
        cur_cfg = rows[i].cfg_sel;
      end
      send_index(rows[i].idx, rows[i].typed, rows[i].res, 18);
    end

    // random phases
    for (int ph = 0; ph < 14; ph++) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      rc = (ph == 0) ? cfgs[4] : random_cfg();
      load_cfg(rc);
      total = element_count();
      max_gap = (ph % 4 == 1) ? 0 : 18;
      for (int k = 0; k < 50; k++) begin
        if (total > 0 && total <= (IDX_MASK + 1) && $urandom_range(0, 4) != 0)
          idx = INDEX_BITS'($urandom_range(0, 32'(total - 1)));
        else
          idx = INDEX_BITS'($urandom);
        send_index(idx, 0, none, max_gap);
      end
    end
    s_tvalid <= 1'b0;

    // end of run
    wait (pending_maps.size() == 0);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/trim_pkg.sv
rtl/trim_cfg.sv
rtl/trim_dim.sv
rtl/tensor_reverse_index_map_unit.sv
verif/testbench.sv
